// File: design/cfr_pkg.sv
`default_nettype none

package cfr_pkg;

    localparam int unsigned ByteW      = 8;
    localparam int unsigned CountW     = 3;
    localparam int unsigned CfgIndexW  = 2;

    localparam logic [ByteW-1:0]  CrcPoly      = 8'h31;
    localparam logic [ByteW-1:0]  CrcTop       = 8'h80;
    localparam logic [ByteW-1:0]  ByteMask     = 8'hff;
    localparam logic [CountW-1:0] HeaderBytes  = 3'd3;
    localparam logic [ByteW-1:0]  StartReset   = 8'd126;
    localparam logic [ByteW-1:0]  ErrCmdReset  = 8'd5;

    typedef enum logic [CfgIndexW-1:0] {
        CFG_START_BYTE = 2'd0,
        CFG_ERR_CMD    = 2'd1
    } t_cfg_index;

    typedef enum logic {
        STATUS_OK      = 1'b0,
        STATUS_CRC_ERR = 1'b1
    } t_status;

    typedef struct packed {
        logic             valid;
        logic [ByteW-1:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        t_status          status;
        logic [ByteW-1:0] command;
        logic [ByteW-1:0] arg0;
        logic [ByteW-1:0] arg1;
    } t_result;

    function automatic logic [ByteW-1:0] crc8_update(
        input logic [ByteW-1:0] crc,
        input logic [ByteW-1:0] b
    );
        logic [ByteW-1:0] acc;
        acc = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if ((acc & CrcTop) != '0) begin
                acc = ((acc << 1) ^ CrcPoly) & ByteMask;
            end else begin
                acc = (acc << 1) & ByteMask;
            end
        end
        return acc;
    endfunction

    function automatic logic [CountW-1:0] args_for(input logic [ByteW-1:0] cmd);
        logic [CountW-1:0] n;
        case (cmd)
            8'd0:    n = 3'd2;
            8'd1:    n = 3'd1;
            8'd2:    n = 3'd1;
            8'd3:    n = 3'd1;
            8'd4:    n = 3'd2;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

// File: design/command_frame_receiver_crc8_top.sv
// Channel   Direction  Handshake                    Payload
// rx        in         i_rx_valid / o_rx_ready      i_rx_byte
// result    out        o_res_valid / i_res_ready    o_status o_command o_arg0 o_arg1
// cfg       in         i_cfg_we (no wait)           i_cfg_index i_cfg_data
//
// One byte per cycle sustained while the result is not stalled; an accepted byte is held
// in the input register, and the frame logic registers a frame's result in the result register.
// The CRC-8 byte update is one unrolled XOR network between input and result registers.
// Synchronous active-low reset returns to hunting the start byte, configuration to defaults.
// A stalled result holds the frame logic; the input register still takes one more byte.
`default_nettype none

module command_frame_receiver_crc8_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [cfr_pkg::CfgIndexW-1:0] i_cfg_index,
    input  wire logic [cfr_pkg::ByteW-1:0]     i_cfg_data,
    input  wire logic                          i_rx_valid,
    output logic                               o_rx_ready,
    input  wire logic [cfr_pkg::ByteW-1:0]     i_rx_byte,
    output logic                               o_res_valid,
    input  wire logic                          i_res_ready,
    output logic                               o_status,
    output logic [cfr_pkg::ByteW-1:0]          o_command,
    output logic [cfr_pkg::ByteW-1:0]          o_arg0,
    output logic [cfr_pkg::ByteW-1:0]          o_arg1
);

    cfr_pkg::t_in_item item;
    cfr_pkg::t_result  res;
    logic              take;

    cfr_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .o_rx_ready (o_rx_ready),
        .i_rx_byte  (i_rx_byte),
        .i_take     (take),
        .o_item     (item)
    );

    cfr_frame u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (item),
        .o_take      (take),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res       (res)
    );

    assign o_status  = res.status;
    assign o_command = res.command;
    assign o_arg0    = res.arg0;
    assign o_arg1    = res.arg1;

endmodule

`default_nettype wire

// File: design/cfr_in_stage.sv
`default_nettype none

module cfr_in_stage (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_rx_valid,
    output logic                       o_rx_ready,
    input  wire logic [cfr_pkg::ByteW-1:0] i_rx_byte,
    input  wire logic                  i_take,
    output cfr_pkg::t_in_item          o_item
);

    logic                      r_valid;
    logic                      n_valid;
    logic [cfr_pkg::ByteW-1:0] r_byte;
    logic [cfr_pkg::ByteW-1:0] n_byte;
    logic                      accept;

    assign o_rx_ready = !r_valid || i_take;
    assign accept     = i_rx_valid && o_rx_ready;

    always_comb begin
        n_valid = r_valid;
        n_byte  = r_byte;
        if (accept) begin
            n_valid = 1'b1;
            n_byte  = i_rx_byte;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    assign o_item.valid   = r_valid;
    assign o_item.rx_byte = r_byte;

    a_take_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take |-> r_valid) else $error("take without held item");

    a_hold_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_take) |=> (r_valid && $stable(r_byte)))
        else $error("held item lost while stalled");

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_valid && r_byte == $past(i_rx_byte)))
        else $error("accepted item not loaded");

endmodule

`default_nettype wire

// File: design/cfr_frame.sv
`default_nettype none

module cfr_frame (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [cfr_pkg::CfgIndexW-1:0] i_cfg_index,
    input  wire logic [cfr_pkg::ByteW-1:0]    i_cfg_data,
    input  wire cfr_pkg::t_in_item            i_item,
    output logic                              o_take,
    output logic                              o_res_valid,
    input  wire logic                         i_res_ready,
    output cfr_pkg::t_result                  o_res
);

    logic [cfr_pkg::ByteW-1:0]  r_start_byte;
    logic [cfr_pkg::ByteW-1:0]  r_err_cmd;

    logic [cfr_pkg::CountW-1:0] r_count;
    logic [cfr_pkg::CountW-1:0] n_count;
    logic [cfr_pkg::ByteW-1:0]  r_cmd;
    logic [cfr_pkg::ByteW-1:0]  n_cmd;
    logic [cfr_pkg::ByteW-1:0]  r_arg0;
    logic [cfr_pkg::ByteW-1:0]  n_arg0;
    logic [cfr_pkg::ByteW-1:0]  r_arg1;
    logic [cfr_pkg::ByteW-1:0]  n_arg1;
    logic [cfr_pkg::ByteW-1:0]  r_crc_rx;
    logic [cfr_pkg::ByteW-1:0]  n_crc_rx;
    logic [cfr_pkg::ByteW-1:0]  r_crc;
    logic [cfr_pkg::ByteW-1:0]  n_crc;

    logic                       r_out_valid;
    logic                       n_out_valid;
    cfr_pkg::t_result           r_res;
    cfr_pkg::t_result           n_res;

    logic                       emit;
    logic [cfr_pkg::CountW-1:0] arg_pos;
    logic [cfr_pkg::CountW-1:0] frame_len;
    logic [cfr_pkg::ByteW-1:0]  b;

    assign b       = i_item.rx_byte;
    assign o_take  = i_item.valid && (!r_out_valid || i_res_ready);
    assign arg_pos = r_count - cfr_pkg::HeaderBytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= cfr_pkg::StartReset;
            r_err_cmd    <= cfr_pkg::ErrCmdReset;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                cfr_pkg::CFG_START_BYTE: r_start_byte <= i_cfg_data;
                cfr_pkg::CFG_ERR_CMD:    r_err_cmd    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_count   = r_count;
        n_cmd     = r_cmd;
        n_arg0    = r_arg0;
        n_arg1    = r_arg1;
        n_crc_rx  = r_crc_rx;
        n_crc     = r_crc;
        emit      = 1'b0;
        frame_len = cfr_pkg::HeaderBytes;
        if (o_take) begin
            case (r_count)
                3'd0: begin
                    if (b == r_start_byte) begin
                        n_count  = 3'd1;
                        n_cmd    = '0;
                        n_arg0   = '0;
                        n_arg1   = '0;
                        n_crc_rx = '0;
                        n_crc    = '0;
                    end
                end
                3'd1: begin
                    n_crc_rx = b;
                    n_count  = 3'd2;
                end
                default: begin
                    if (r_count == 3'd2) begin
                        n_cmd = b;
                    end else if (arg_pos[0]) begin
                        n_arg1 = b;
                    end else begin
                        n_arg0 = b;
                    end
                    n_crc     = cfr_pkg::crc8_update(r_crc, b);
                    n_count   = r_count + 3'd1;
                    frame_len = cfr_pkg::HeaderBytes + cfr_pkg::args_for(n_cmd);
                    if (n_count >= frame_len) begin
                        emit    = 1'b1;
                        n_count = '0;
                    end
                end
            endcase
        end
    end

    always_comb begin
        n_out_valid = r_out_valid && !i_res_ready;
        n_res       = r_res;
        if (emit) begin
            n_out_valid = 1'b1;
            if (n_crc == r_crc_rx) begin
                n_res.status  = cfr_pkg::STATUS_OK;
                n_res.command = n_cmd;
                n_res.arg0    = n_arg0;
                n_res.arg1    = n_arg1;
            end else begin
                n_res.status  = cfr_pkg::STATUS_CRC_ERR;
                n_res.command = r_err_cmd;
                n_res.arg0    = r_crc_rx;
                n_res.arg1    = n_crc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_arg0   <= n_arg0;
        r_arg1   <= n_arg1;
        r_crc_rx <= n_crc_rx;
        r_crc    <= n_crc;
        r_res    <= n_res;
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_res;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'd4) else $error("frame byte count out of range");

    a_emit_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> (r_count == '0 && r_out_valid)) else $error("frame end not handled");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_res_ready) |-> !o_take) else $error("pending result overrun");

    a_idle_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && r_count == '0 && b != r_start_byte) |=> (r_count == '0))
        else $error("non-start byte opened a frame");

endmodule

`default_nettype wire
